@@ rtl/ptts_pkg.sv @@
// package for the periodic task tick scheduler
// holds sizes, register indexes, controller states and the controller/datapath structs
// no dependencies
package ptts_pkg;

	localparam int TASK_COUNT = 4;
	localparam int TIME_WIDTH = 16;
	localparam int CD_WIDTH   = TIME_WIDTH + 2;
	localparam int TASK_IDX_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;
	localparam int ACTIVE_W   = 3;

	localparam logic [CFG_IDX_W-1:0] REG_POLICY = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TASK0  = 3'd2;

	// policy codes
	localparam logic POLICY_RM  = 1'b0;
	localparam logic POLICY_EDF = 1'b1;

	// most negative deadline countdown
	localparam logic signed [CD_WIDTH-1:0] CD_MIN = {1'b1, {(CD_WIDTH-1){1'b0}}};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} ptts_state_t;

	// controller to datapath
	typedef struct packed {
		logic start;
		logic step;
		logic commit;
	} ptts_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
	} ptts_sts_t;

endpackage

@@ rtl/periodic_task_tick_scheduler.sv @@
// Periodic task tick scheduler, rate monotonic or earliest deadline first.
// Each request on the s_ side is one scheduler tick; it gives exactly one request
// on the m_ side naming the task that runs in that tick, or idle.
// Configuration writes (policy, active task count, per-task period, execution
// time and deadline) go over the cfg_ channel, which is always ready; write only
// while no tick is in progress.
// Sequence: a tick is accepted when s_tready is high, then the sequencer visits
// one task per cycle in ST_SCAN, then commits the result in ST_DONE.
// The result register lets a new tick be accepted while the previous result waits;
// if the receiver still stalls at commit time, the sequencer holds in its last
// step until the result register frees.
// Reset clears all task state, sets policy to rate monotonic, one active task
// and all task parameters to zero; the block is ready straight after reset.
// Depends on ptts_pkg, ptts_ctrl and ptts_dp.
module periodic_task_tick_scheduler (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // [0] restart, [7:1] zero
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [7:0]                      m_tdata,   // [1:0] selected_task, [7:2] zero
	output logic                            m_tuser,   // [0] idle
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ptts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ptts_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ptts_pkg::*;

	ptts_cmd_t  cmd;
	ptts_sts_t  sts;
	logic [1:0] selected_task;

	assign cfg_ready = 1'b1;

	ptts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	ptts_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.restart       (s_tdata[0]),
		.cmd           (cmd),
		.sts           (sts),
		.selected_task (selected_task),
		.idle          (m_tuser)
	);

	// pack result
	assign m_tdata = {6'd0, selected_task};

endmodule

@@ rtl/ptts_ctrl.sv @@
// sequencer for the tick scheduler: accept, scan over tasks, commit result
// depends on ptts_pkg
module ptts_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	output ptts_pkg::ptts_cmd_t cmd,
	input  ptts_pkg::ptts_sts_t sts
);
	import ptts_pkg::*;

	ptts_state_t state_q, state_d;
	logic        m_tvalid_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_SCAN;
			ST_SCAN: if (sts.scan_last) state_d = ST_DONE;
			ST_DONE: if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and commands
	always_comb begin
		s_tready   = (state_q == ST_IDLE);
		cmd.start  = (state_q == ST_IDLE) && s_tvalid;
		cmd.step   = (state_q == ST_SCAN);
		cmd.commit = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);
	end

	assign m_tvalid = m_tvalid_q;

	// state and result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

endmodule

@@ rtl/ptts_dp.sv @@
// datapath of the tick scheduler: config registers, per-task state, scan compare
// depends on ptts_pkg
module ptts_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [ptts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ptts_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            restart,
	input  ptts_pkg::ptts_cmd_t             cmd,
	output ptts_pkg::ptts_sts_t             sts,
	output logic [1:0]                      selected_task,
	output logic                            idle
);
	import ptts_pkg::*;

	// configuration
	logic                  policy_q;
	logic [ACTIVE_W-1:0]   active_q;
	logic [TIME_WIDTH-1:0] period_q [TASK_COUNT];
	logic [TIME_WIDTH-1:0] exec_q   [TASK_COUNT];
	logic [TIME_WIDTH-1:0] dl_q     [TASK_COUNT];

	// task state
	logic        [TIME_WIDTH-1:0] phase_q [TASK_COUNT];
	logic        [TIME_WIDTH-1:0] work_q  [TASK_COUNT];
	logic signed [CD_WIDTH-1:0]   cd_q    [TASK_COUNT];

	// scan state
	logic                         restart_q;
	logic [TASK_IDX_W-1:0]        idx_q;
	logic                         found_q;
	logic [TASK_IDX_W-1:0]        chosen_q;
	logic [TIME_WIDTH-1:0]        best_per_q;
	logic signed [CD_WIDTH-1:0]   best_cd_q;
	logic [1:0]                   sel_q;
	logic                         idle_q;

	logic [CFG_IDX_W-1:0]         cfg_slot;
	logic                         cfg_task_hit;

	logic                         en;
	logic        [TIME_WIDTH-1:0] ph, wl;
	logic signed [CD_WIDTH-1:0]   cd;
	logic                         cand, better;
	logic        [TIME_WIDTH:0]   ph_next;
	logic        [TIME_WIDTH-1:0] ph_new;
	logic signed [CD_WIDTH-1:0]   cd_new;

	assign cfg_slot     = cfg_index - REG_TASK0;
	assign cfg_task_hit = (cfg_index >= REG_TASK0) && (int'(cfg_slot) < TASK_COUNT);

	assign sts.scan_last = (idx_q == TASK_IDX_W'(TASK_COUNT - 1));

	// one task per cycle: clear, release, candidacy, time advance
	always_comb begin
		en = (ACTIVE_W'(idx_q) < active_q) && (period_q[idx_q] != '0);
		ph = phase_q[idx_q];
		wl = work_q[idx_q];
		cd = cd_q[idx_q];
		if (restart_q || !en) begin
			ph = '0;
			wl = '0;
			cd = '0;
		end
		if (en && ph == '0) begin
			wl = exec_q[idx_q];
			cd = $signed({2'b00, dl_q[idx_q]});
		end
		cand = en && (wl != '0);
		if (policy_q == POLICY_EDF)
			better = !found_q || (cd < best_cd_q);
		else
			better = !found_q || (period_q[idx_q] < best_per_q);
		ph_next = {1'b0, ph} + (TIME_WIDTH+1)'(1);
		ph_new  = ph;
		cd_new  = cd;
		if (en) begin
			ph_new = (ph_next >= {1'b0, period_q[idx_q]}) ? '0 : ph_next[TIME_WIDTH-1:0];
			if (cd > CD_MIN)
				cd_new = cd - CD_WIDTH'(1);
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POLICY_RM;
			active_q <= ACTIVE_W'(1);
			for (int i = 0; i < TASK_COUNT; i++) begin
				period_q[i] <= '0;
				exec_q[i]   <= '0;
				dl_q[i]     <= '0;
			end
		end else if (cfg_valid) begin
			if (cfg_index == REG_POLICY)
				policy_q <= cfg_data[0];
			else if (cfg_index == REG_ACTIVE)
				active_q <= cfg_data[ACTIVE_W-1:0];
			else if (cfg_task_hit) begin
				period_q[cfg_slot[TASK_IDX_W-1:0]] <= cfg_data[TIME_WIDTH-1:0];
				exec_q[cfg_slot[TASK_IDX_W-1:0]]   <= cfg_data[16 +: TIME_WIDTH];
				dl_q[cfg_slot[TASK_IDX_W-1:0]]     <= cfg_data[32 +: TIME_WIDTH];
			end
		end
	end

	// task state and scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TASK_COUNT; i++) begin
				phase_q[i] <= '0;
				work_q[i]  <= '0;
				cd_q[i]    <= '0;
			end
			restart_q <= 1'b0;
			idx_q     <= '0;
			found_q   <= 1'b0;
		end else begin
			if (cmd.start) begin
				restart_q <= restart;
				idx_q     <= '0;
				found_q   <= 1'b0;
			end
			if (cmd.step) begin
				phase_q[idx_q] <= ph_new;
				work_q[idx_q]  <= wl;
				cd_q[idx_q]    <= cd_new;
				idx_q          <= idx_q + TASK_IDX_W'(1);
				if (cand && better)
					found_q <= 1'b1;
			end
			if (cmd.commit && found_q)
				work_q[chosen_q] <= work_q[chosen_q] - TIME_WIDTH'(1);
		end
	end

	// best-so-far payload and result register
	always_ff @(posedge clk) begin
		if (cmd.step && cand && better) begin
			chosen_q   <= idx_q;
			best_per_q <= period_q[idx_q];
			best_cd_q  <= cd;
		end
		if (cmd.commit) begin
			sel_q  <= found_q ? 2'(chosen_q) : 2'd0;
			idle_q <= !found_q;
		end
	end

	assign selected_task = sel_q;
	assign idle          = idle_q;

endmodule

@@ rtl/ptts_checker.sv @@
// port-level checks for the tick scheduler, bound to the top level
// depends on periodic_task_tick_scheduler
module ptts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tuser
);

	// an idle result names task zero
	a_idle_sel: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[1:0] == 2'd0)
		else $error("idle result with nonzero task");

	// one tick in flight: an accepted request drops ready
	a_one_tick: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second tick accepted during scan");

	// a new result only appears at the end of a scan
	a_result_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result raised while idle");

	// returning to idle always leaves a result behind
	a_ready_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s_tready) |-> m_tvalid)
		else $error("scan finished without result");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind periodic_task_tick_scheduler ptts_checker u_ptts_checker (.*);

@@ dv/periodic_task_tick_scheduler_tb.sv @@
// self-checking testbench for the periodic task tick scheduler
// a scoreboard class predicts each tick's pick from its own copy of the task state
// depends on ptts_pkg and periodic_task_tick_scheduler
`timescale 1ns / 100ps

module periodic_task_tick_scheduler_tb;
	import ptts_pkg::*;

	localparam int RANDOM_TICKS = 1700;
	localparam int DRAIN_CYCLES = TASK_COUNT + 8;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 200;
	localparam int MAX_REPORTS  = 10;

	// register indexes past the task list, written to check they are ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE0 = CFG_IDX_W'(REG_TASK0 + TASK_COUNT);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE1 = CFG_IDX_W'(REG_TASK0 + TASK_COUNT + 1);

	typedef struct packed {
		logic [1:0] task_id;
		logic       idle;
	} tick_pick_t;

	// scheduler predictor and the queue of picks still to come out
	class tick_scoreboard;
		logic                        policy;
		logic [ACTIVE_W-1:0]         active;
		logic [TIME_WIDTH-1:0]       period[TASK_COUNT];
		logic [TIME_WIDTH-1:0]       exec_time[TASK_COUNT];
		logic [TIME_WIDTH-1:0]       rel_deadline[TASK_COUNT];
		logic [TIME_WIDTH-1:0]       phase[TASK_COUNT];
		logic [TIME_WIDTH-1:0]       work[TASK_COUNT];
		logic signed [CD_WIDTH-1:0]  countdown[TASK_COUNT];
		tick_pick_t                  expected_picks[$];
		int                          picks_seen;
		int                          mismatches;

		function new();
			policy = POLICY_RM;
			active = ACTIVE_W'(1);
			picks_seen = 0;
			mismatches = 0;
			for (int i = 0; i < TASK_COUNT; i++) begin
				period[i] = '0;
				exec_time[i] = '0;
				rel_deadline[i] = '0;
				phase[i] = '0;
				work[i] = '0;
				countdown[i] = '0;
			end
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			int t;
			t = int'(index) - int'(REG_TASK0);
			if (index == REG_POLICY) begin
				policy = data[0];
			end else if (index == REG_ACTIVE) begin
				active = data[ACTIVE_W-1:0];
			end else if (index >= REG_TASK0 && t < TASK_COUNT) begin
				period[t]       = data[15:0];
				exec_time[t]    = data[31:16];
				rel_deadline[t] = data[47:32];
			end
		endfunction

		// one scheduler tick: clear, release, pick, then advance phases and countdowns
		function tick_pick_t schedule_tick(logic restart);
			logic                       enabled[TASK_COUNT];
			logic                       found;
			int                         chosen;
			logic [TIME_WIDTH-1:0]      best_period;
			logic signed [CD_WIDTH-1:0] best_cd;
			logic [TIME_WIDTH:0]        next_phase;
			tick_pick_t                 pick;
			found = 1'b0;
			chosen = 0;
			best_period = '0;
			best_cd = '0;
			for (int i = 0; i < TASK_COUNT; i++) begin
				enabled[i] = (i < int'(active)) && (period[i] != '0);
				if (restart || !enabled[i]) begin
					phase[i] = '0;
					work[i] = '0;
					countdown[i] = '0;
				end
			end
			// release jobs whose phase is at zero
			for (int i = 0; i < TASK_COUNT; i++) begin
				if (enabled[i] && phase[i] == '0) begin
					work[i] = exec_time[i];
					countdown[i] = $signed({2'b00, rel_deadline[i]});
				end
			end
			// pick among pending tasks, lowest index wins ties
			for (int i = 0; i < TASK_COUNT; i++) begin
				if (enabled[i] && work[i] != '0) begin
					if (policy == POLICY_RM) begin
						if (!found || period[i] < best_period) begin
							found = 1'b1;
							chosen = i;
							best_period = period[i];
						end
					end else begin
						if (!found || countdown[i] < best_cd) begin
							found = 1'b1;
							chosen = i;
							best_cd = countdown[i];
						end
					end
				end
			end
			if (found)
				work[chosen] = work[chosen] - TIME_WIDTH'(1);
			// advance time, countdowns saturate at the most negative value
			for (int i = 0; i < TASK_COUNT; i++) begin
				if (enabled[i]) begin
					next_phase = {1'b0, phase[i]} + (TIME_WIDTH+1)'(1);
					phase[i] = (next_phase >= {1'b0, period[i]}) ? '0 : next_phase[TIME_WIDTH-1:0];
					if (countdown[i] > CD_MIN)
						countdown[i] = countdown[i] - CD_WIDTH'(1);
				end
			end
			pick.task_id = found ? chosen[1:0] : 2'd0;
			pick.idle = !found;
			return pick;
		endfunction

		function void note_tick(logic restart);
			expected_picks.push_back(schedule_tick(restart));
		endfunction

		function void check_result(logic [1:0] task_id, logic idle);
			tick_pick_t want;
			picks_seen++;
			if (expected_picks.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("result %0d: unexpected, task %0d idle %0b", picks_seen,
						task_id, idle);
				return;
			end
			want = expected_picks.pop_front();
			if (task_id !== want.task_id || idle !== want.idle) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("result %0d: expected task %0d idle %0b, got task %0d idle %0b",
						picks_seen, want.task_id, want.idle, task_id, idle);
			end
		endfunction

		function int pending();
			return expected_picks.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [7:0]            m_tdata;
	logic                  m_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	tick_scoreboard sb;
	int             ticks_accepted;
	int             send_idle_pct;
	int             recv_idle_pct;
	int             cycles;

	periodic_task_tick_scheduler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// result side: check accepted picks, random stalls and one long hold-off
	initial begin
		int  hold_left;
		bit  hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata[1:0], m_tuser);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!hold_done && ticks_accepted >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// one configuration request
	task automatic cfg_write(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(index, data);
	endtask

	// one tick request, with random gaps ahead of it
	task automatic send_tick(logic restart);
		cfg_valid <= 1'b0;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, restart};
		do @(posedge clk); while (!s_tready);
		sb.note_tick(restart);
		ticks_accepted++;
	endtask

	task automatic run_ticks(int count, logic first_restart);
		for (int i = 0; i < count; i++)
			send_tick(i == 0 ? first_restart : 1'b0);
	endtask

	// wait for every pick to come out and the sequencer to settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] task_params(int p, int e, int d);
		return {d[15:0], e[15:0], p[15:0]};
	endfunction

	// mostly short periods so jobs release often, sometimes disabled or wide
	function automatic logic [CFG_DATA_W-1:0] random_params();
		int r;
		int p;
		r = $urandom_range(0, 11);
		if (r == 0)
			return CFG_DATA_W'({$urandom(), $urandom()});
		p = (r == 1) ? 0 : (r == 2) ? $urandom_range(13, 16'hffff) : $urandom_range(1, 12);
		return task_params(p, $urandom_range(0, (p > 12 ? 12 : p) + 2),
			$urandom_range(0, 2 * (p > 12 ? 12 : p) + 1));
	endfunction

	// random settings between bursts of ticks
	task automatic random_phase();
		int ticks;
		drain();
		if ($urandom_range(3) != 0)
			cfg_write(REG_POLICY, CFG_DATA_W'({$urandom(), $urandom()}));
		if ($urandom_range(3) != 0)
			cfg_write(REG_ACTIVE, ($urandom_range(7) == 0) ? CFG_DATA_W'($urandom_range(0, 7))
				: CFG_DATA_W'($urandom_range(1, TASK_COUNT)));
		for (int t = 0; t < TASK_COUNT; t++)
			if ($urandom_range(2) != 0)
				cfg_write(CFG_IDX_W'(REG_TASK0 + t), random_params());
		if ($urandom_range(9) == 0)
			cfg_write($urandom_range(0, 1) ? REG_SPARE0 : REG_SPARE1,
				CFG_DATA_W'({$urandom(), $urandom()}));
		ticks = $urandom_range(20, 60);
		// restart mostly at the start of a burst, occasionally in the middle
		for (int i = 0; i < ticks; i++)
			send_tick((i == 0 && $urandom_range(3) != 0) || $urandom_range(39) == 0);
	endtask

	initial begin
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		arst_n    <= 1'b0;
		ticks_accepted = 0;
		send_idle_pct = 11;
		recv_idle_pct = 66;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: one active task with period zero, so idle
		run_ticks(2, 1'b0);

		// rate monotonic with a disabled task and one of zero execution time
		drain();
		cfg_write(REG_POLICY, CFG_DATA_W'(POLICY_RM));
		cfg_write(REG_ACTIVE, CFG_DATA_W'(TASK_COUNT));
		cfg_write(CFG_IDX_W'(REG_TASK0 + 0), task_params(4, 1, 4));
		cfg_write(CFG_IDX_W'(REG_TASK0 + 1), task_params(3, 1, 3));
		cfg_write(CFG_IDX_W'(REG_TASK0 + 2), task_params(0, 3, 3));
		cfg_write(CFG_IDX_W'(REG_TASK0 + 3), task_params(6, 0, 2));
		run_ticks(5, 1'b1);

		// earliest deadline with overrun, missed deadline and all-ones fields
		drain();
		cfg_write(REG_POLICY, CFG_DATA_W'(POLICY_EDF));
		cfg_write(CFG_IDX_W'(REG_TASK0 + 0), task_params(2, 5, 0));
		cfg_write(CFG_IDX_W'(REG_TASK0 + 1), {CFG_DATA_W{1'b1}});
		cfg_write(CFG_IDX_W'(REG_TASK0 + 2), task_params(5, 2, 1));
		cfg_write(CFG_IDX_W'(REG_TASK0 + 3), task_params(1, 1, 16'hffff));
		run_ticks(5, 1'b1);

		// no active task, then more than there are, and spare indexes
		drain();
		cfg_write(REG_ACTIVE, CFG_DATA_W'(0));
		cfg_write(REG_SPARE0, {CFG_DATA_W{1'b1}});
		run_ticks(2, 1'b0);
		drain();
		cfg_write(REG_ACTIVE, {CFG_DATA_W{1'b1}});
		cfg_write(REG_SPARE1, '0);
		run_ticks(2, 1'b0);

		// period lowered under the running phase without a restart
		drain();
		cfg_write(REG_ACTIVE, CFG_DATA_W'(1));
		cfg_write(REG_TASK0, task_params(10, 1, 10));
		run_ticks(4, 1'b1);
		drain();
		cfg_write(REG_TASK0, task_params(2, 1, 2));
		run_ticks(3, 1'b0);

		// random part, idling swapped between the two sides, then none
		while (ticks_accepted < RANDOM_TICKS) begin
			if (ticks_accepted >= 2 * RANDOM_TICKS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (ticks_accepted >= RANDOM_TICKS / 3) begin
				send_idle_pct = 66;
				recv_idle_pct = 11;
			end
			random_phase();
		end

		drain();
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
